/* hw/rtl/wts_pkg.sv */
// Shared constants for the windowed temperature statistics block.
// No dependencies; used by the top level.
package wts_pkg;

  // field widths of the sample and result fields
  localparam int SAMPLE_W = 12;
  localparam int LOW_W    = 14;

  // default ring depth
  localparam int WINDOW_DEF = 16;

  // running extremes after reset: highest starts at zero, lowest at 500.0 degrees
  localparam logic signed [SAMPLE_W-1:0] HIGH_START = '0;
  localparam logic signed [LOW_W-1:0]    LOW_START  = 14'sd5000;

endpackage

/* hw/rtl/wts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wts_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/wts_div.sv */
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
// No dependencies; used by the top level for the window average.
module wts_div #(
  parameter int DIVIDEND_W = 16,
  parameter int DIVISOR_W  = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [DIVISOR_W:0]    rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;

  logic [DIVISOR_W:0]    rem_shift;
  logic [DIVISOR_W+1:0]  diff;
  logic                  fits;

  // one restoring step: bring down the next dividend bit and try the subtract
  assign rem_shift = {rem_r[DIVISOR_W-1:0], quo_r[DIVIDEND_W-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, dvs_r};
  assign fits      = !diff[DIVISOR_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[DIVISOR_W:0] : rem_shift;
      quo_nxt  = {quo_r[DIVIDEND_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* hw/rtl/windowed_temperature_statistics.sv */
// Windowed temperature statistics: top level.
// Depends on wts_pkg, wts_ram (sample ring) and wts_div (serial divider).
//
// Usage:
//   Input channel in_valid/in_ready/in_sample takes one signed 12-bit sample in
//   tenths of a degree per request. Each request gives exactly one result on
//   out_valid/out_ready: the sample, the highest and lowest samples since reset
//   (starting at 0 and 5000 tenths) and the mean of the last WINDOW samples
//   (of all samples so far while the ring fills), truncated toward zero.
//   One request is processed at a time. After acceptance, the update state
//   writes the ring and updates the sum and extremes, the start state loads
//   the divider, the bit-serial divider forms the average, and the finish
//   state moves the result into the output register once that is free; the
//   next request is accepted only after that. The divider sets the rate.
//   The result sits in an output register, so the next sample is accepted and
//   processed while the receiver stalls; only a second finished result waits
//   for the output register to drain.
//   Synchronous active-low reset clears the fill count, sum, extremes and
//   handshake state; the ring needs no clearing since data from unfilled slots
//   is never used.
module windowed_temperature_statistics #(
  parameter int WINDOW = wts_pkg::WINDOW_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [wts_pkg::SAMPLE_W-1:0]     in_sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [wts_pkg::SAMPLE_W-1:0]     out_current_value,
  output logic signed [wts_pkg::SAMPLE_W-1:0]     out_highest_seen,
  output logic signed [wts_pkg::LOW_W-1:0]        out_lowest_seen,
  output logic signed [wts_pkg::SAMPLE_W-1:0]     out_window_average
);

  localparam int SW     = wts_pkg::SAMPLE_W;
  localparam int LW     = wts_pkg::LOW_W;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(WINDOW) + SW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_START,
    S_DIV,
    S_DONE
  } state_t;

  state_t                  state_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [CNT_W-1:0]        fill_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SW-1:0]    max_r;
  logic signed [LW-1:0]    min_r;
  logic signed [SW-1:0]    sample_r;
  logic                    neg_r;
  logic                    out_valid_r;
  logic signed [SW-1:0]    out_cur_r;
  logic signed [SW-1:0]    out_max_r;
  logic signed [LW-1:0]    out_min_r;
  logic signed [SW-1:0]    out_avg_r;

  logic                    full;
  logic                    ram_we;
  logic [SW-1:0]           ram_rdata;
  logic signed [SUM_W-1:0] drop;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [SUM_W-1:0]        sum_mag;
  logic                    div_start;
  logic                    div_done;
  logic [SUM_W-1:0]        div_quo;
  logic [SW-1:0]           avg_mag;
  logic signed [SW-1:0]    avg;
  logic                    accept;
  logic                    out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign full     = (fill_r == CNT_W'(WINDOW));

  // sample ring, read address always at the slot about to be overwritten
  assign ram_we = (state_r == S_UPDATE);

  wts_ram #(
    .WIDTH (SW),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (sample_r),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  // running sum: drop the oldest sample once the ring is full
  assign drop    = full ? SUM_W'($signed(ram_rdata)) : '0;
  assign sum_nxt = sum_r + SUM_W'(sample_r) - drop;

  // divider works on the magnitude of the sum
  assign sum_mag   = sum_r[SUM_W-1] ? $unsigned(-sum_r) : $unsigned(sum_r);
  assign div_start = (state_r == S_START);

  wts_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (fill_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // restore the sign of the average
  assign avg_mag = div_quo[SW-1:0];
  assign avg     = neg_r ? $signed(~avg_mag + 1'b1) : $signed(avg_mag);

  // sequencer, window state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      max_r       <= wts_pkg::HIGH_START;
      min_r       <= wts_pkg::LOW_START;
      out_valid_r <= 1'b0;
    end else begin
      // result drained; the finish state reloads the register itself
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            sample_r <= in_sample;
            state_r  <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          sum_r <= sum_nxt;
          if (!full) begin
            fill_r <= fill_r + 1'b1;
          end
          slot_r <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
          if (sample_r > max_r) begin
            max_r <= sample_r;
          end
          if (LW'(sample_r) < min_r) begin
            min_r <= LW'(sample_r);
          end
          state_r <= S_START;
        end
        S_START: begin
          neg_r   <= sum_r[SUM_W-1];
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_cur_r   <= sample_r;
            out_max_r   <= max_r;
            out_min_r   <= min_r;
            out_avg_r   <= avg;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_current_value  = out_cur_r;
  assign out_highest_seen   = out_max_r;
  assign out_lowest_seen    = out_min_r;
  assign out_window_average = out_avg_r;

  // fill count never passes the ring depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW))
    else $error("fill count beyond ring depth");

  // divider only finishes while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider done outside divide state");

  // a new result only appears from the finish state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside finish state");

  // highest seen never drops below its start value of zero
  a_max_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_START |-> !max_r[SW-1])
    else $error("highest seen went negative");

  // an accepted request always goes straight to the update step
  a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_UPDATE)
    else $error("accepted request not updated");

endmodule
